[hw/rtl/omni_mix_pkg.sv]
// Package for the three-wheel omni drive mixer: shared widths, types, reset values
// and the elaboration-time arctangent table functions.
// No dependencies.
package omni_mix_pkg;

  localparam int RAW_W       = 16;
  localparam int SCL_W       = 10;
  localparam int LIM_W       = 9;
  localparam int WHL_W       = 11;
  localparam int MAG_W       = 9;
  localparam int HDG_W       = 9;
  localparam int SPD_W       = 10;
  localparam int SQ_W        = 19;
  localparam int SQRT_STEPS  = 10;
  localparam int COORD_SHIFT = 32;
  localparam int CRD_W       = 46;
  localparam int TABLE_BITS  = 56;

  localparam logic [0:0] REG_NEUTRAL = 1'b0;
  localparam logic [0:0] REG_LIMIT   = 1'b1;

  localparam logic [RAW_W-1:0] NEUTRAL_RESET = 16'h8000;
  localparam logic [LIM_W-1:0] LIMIT_RESET   = 9'd500;

  localparam int ATAN_POW2 = 0;
  localparam int ATAN_FIVE = 1;
  localparam int ATAN_239  = 2;

  typedef logic signed [SCL_W-1:0] scaled_t;

  typedef struct packed {
    scaled_t y;
    scaled_t x;
    scaled_t rot;
  } scaled_cmd_t;

  typedef struct packed {
    logic [SPD_W-1:0] speed;
    logic [HDG_W-1:0] heading;
    scaled_t          rot;
  } vector_t;

  // arctangent of 1/m in units of 2^-56 rad, m = 2^sh, 5 or 239
  function automatic logic [63:0] atan_recip(input int mode, input int sh);
    logic [63:0] p;
    logic [63:0] sum;
    logic [63:0] t;
    logic        done;
    case (mode)
      ATAN_FIVE: p = (64'd1 << TABLE_BITS) / 64'd5;
      ATAN_239:  p = (64'd1 << TABLE_BITS) / 64'd239;
      default:   p = (64'd1 << TABLE_BITS) >> sh;
    endcase
    sum  = p;
    done = 1'b0;
    for (int k = 1; k < 64; k++) begin
      if (!done) begin
        case (mode)
          ATAN_FIVE: p = p / 64'd25;
          ATAN_239:  p = p / 64'd57121;
          default:   p = p >> (2 * sh);
        endcase
        if (p == 64'd0) begin
          done = 1'b1;
        end else begin
          t = p / 64'(2 * k + 1);
          if ((k % 2) == 1) begin
            sum = sum - t;
          end else begin
            sum = sum + t;
          end
        end
      end
    end
    return sum;
  endfunction

  // arctangent of 2^-i in units of 2^-frac scaled degrees
  function automatic logic [63:0] step_angle(input int i, input int frac);
    logic [63:0] r;
    logic [63:0] deg;
    if (i == 0) begin
      r = 64'd4 * atan_recip(ATAN_FIVE, 0) - atan_recip(ATAN_239, 0);
    end else begin
      r = atan_recip(ATAN_POW2, i);
    end
    deg = (r / 64'd10000) * 64'd572958 + ((r % 64'd10000) * 64'd572958) / 64'd10000;
    return deg >> (TABLE_BITS - frac);
  endfunction

endpackage

[hw/rtl/omni_mix_scale.sv]
// Command scaling: centres the three raw commands on the neutral point and scales
// them by 500/65535 with truncation toward zero, over two register stages.
// Depends on omni_mix_pkg.
module omni_mix_scale (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             en,
  input  logic                             in_valid,
  input  logic [omni_mix_pkg::RAW_W-1:0]   y_command,
  input  logic [omni_mix_pkg::RAW_W-1:0]   x_command,
  input  logic [omni_mix_pkg::RAW_W-1:0]   rotation_command,
  input  logic [omni_mix_pkg::RAW_W-1:0]   neutral,
  output logic                             out_valid,
  output omni_mix_pkg::scaled_cmd_t        out_cmd
);
  import omni_mix_pkg::*;

  localparam int PROD_W = 25;
  localparam int SUM_W  = PROD_W + 1;

  logic [RAW_W-1:0]  raw   [3];
  logic [PROD_W-1:0] prod  [3];
  logic              neg   [3];
  logic [PROD_W-1:0] prod_q [3];
  logic              neg_q  [3];
  scaled_t           scl   [3];
  logic              vld_q;

  assign raw[0] = y_command;
  assign raw[1] = x_command;
  assign raw[2] = rotation_command;

  for (genvar l = 0; l < 3; l++) begin : g_lane
    logic signed [RAW_W:0] diff;
    logic [RAW_W-1:0]      mag;
    logic [SUM_W-1:0]      quot_sum;
    logic [LIM_W-1:0]      quot;

    always_comb begin
      diff    = $signed({1'b0, raw[l]}) - $signed({1'b0, neutral});
      neg[l]  = diff[RAW_W];
      mag     = neg[l] ? RAW_W'(-diff) : diff[RAW_W-1:0];
      prod[l] = PROD_W'(mag) * PROD_W'(500);
    end

    always_comb begin
      quot_sum = SUM_W'(prod_q[l]) + SUM_W'(prod_q[l] >> 16) + SUM_W'(1);
      quot     = quot_sum[16 +: LIM_W];
      scl[l]   = neg_q[l] ? -$signed({1'b0, quot}) : $signed({1'b0, quot});
    end

    always_ff @(posedge clk) begin
      if (en) begin
        prod_q[l] <= prod[l];
        neg_q[l]  <= neg[l];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_cmd.y   <= scl[0];
      out_cmd.x   <= scl[1];
      out_cmd.rot <= scl[2];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_q     <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      vld_q     <= in_valid;
      out_valid <= vld_q;
    end
  end

endmodule

[hw/rtl/omni_mix_vector.sv]
// Vector unit: pipelined vectoring CORDIC for the heading and a digit-by-digit
// square root for the speed, one step per register stage.
// Depends on omni_mix_pkg.
module omni_mix_vector #(
  parameter int ANGLE_FRAC_BITS = 20
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      en,
  input  logic                      in_valid,
  input  omni_mix_pkg::scaled_cmd_t in_cmd,
  output logic                      out_valid,
  output omni_mix_pkg::vector_t     out_vec
);
  import omni_mix_pkg::*;

  localparam int STEPS = ANGLE_FRAC_BITS + 8;
  localparam int ACC_W = ANGLE_FRAC_BITS + 10;
  localparam int RT_W  = SQ_W + 1;
  localparam int WH_W  = ACC_W + 1 - ANGLE_FRAC_BITS;

  localparam logic signed [ACC_W-1:0] QUARTER = ACC_W'(64'd2 * step_angle(0, ANGLE_FRAC_BITS));
  localparam logic signed [ACC_W:0]   FULL_TURN = (ACC_W + 1)'(64'd360 << ANGLE_FRAC_BITS);

  logic                    vld  [STEPS+1];
  logic signed [CRD_W-1:0] ca   [STEPS+1];
  logic signed [CRD_W-1:0] cb   [STEPS+1];
  logic signed [ACC_W-1:0] acc  [STEPS+1];
  logic [SQ_W-1:0]         rem  [STEPS+1];
  logic [RT_W-1:0]         root [STEPS+1];
  scaled_t                 rot  [STEPS+1];
  logic                    xzero [STEPS+1];
  logic                    yneg  [STEPS+1];

  // entry: pre-rotate the lower half plane, form the squared length
  logic signed [CRD_W-1:0] ya, xb, a0, b0;
  logic signed [ACC_W-1:0] acc0;
  logic [LIM_W-1:0]        ax, ay;
  logic [SQ_W-1:0]         sq;

  always_comb begin
    ya = $signed(CRD_W'($signed(in_cmd.y))) <<< COORD_SHIFT;
    xb = $signed(CRD_W'($signed(in_cmd.x))) <<< COORD_SHIFT;
    a0   = ya;
    b0   = xb;
    acc0 = '0;
    if (ya[CRD_W-1]) begin
      if (!xb[CRD_W-1]) begin
        a0   = xb;
        b0   = -ya;
        acc0 = QUARTER;
      end else begin
        a0   = -xb;
        b0   = ya;
        acc0 = -QUARTER;
      end
    end
    ax = in_cmd.x[SCL_W-1] ? LIM_W'(-in_cmd.x) : in_cmd.x[LIM_W-1:0];
    ay = in_cmd.y[SCL_W-1] ? LIM_W'(-in_cmd.y) : in_cmd.y[LIM_W-1:0];
    sq = SQ_W'(ax) * SQ_W'(ax) + SQ_W'(ay) * SQ_W'(ay);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ca[0]    <= a0;
      cb[0]    <= b0;
      acc[0]   <= acc0;
      rem[0]   <= sq;
      root[0]  <= '0;
      rot[0]   <= in_cmd.rot;
      xzero[0] <= (in_cmd.x == '0);
      yneg[0]  <= in_cmd.y[SCL_W-1];
    end
  end

  for (genvar i = 0; i < STEPS; i++) begin : g_step
    localparam logic signed [ACC_W-1:0] DELTA = ACC_W'(step_angle(i, ANGLE_FRAC_BITS));

    logic signed [CRD_W-1:0] ai, bi, a_n, b_n;
    logic signed [ACC_W-1:0] acc_n;
    logic [SQ_W-1:0]         rem_n;
    logic [RT_W-1:0]         root_n;

    always_comb begin
      ai = ca[i] >>> i;
      bi = cb[i] >>> i;
      if (!cb[i][CRD_W-1]) begin
        a_n   = ca[i] + bi;
        b_n   = cb[i] - ai;
        acc_n = acc[i] + DELTA;
      end else begin
        a_n   = ca[i] - bi;
        b_n   = cb[i] + ai;
        acc_n = acc[i] - DELTA;
      end
    end

    if (i < SQRT_STEPS) begin : g_sqrt
      localparam logic [RT_W-1:0] BIT = RT_W'(1) << (2 * (SQRT_STEPS - 1 - i));
      logic [RT_W-1:0] trial;
      always_comb begin
        trial = root[i] + BIT;
        if (RT_W'(rem[i]) >= trial) begin
          rem_n  = SQ_W'(RT_W'(rem[i]) - trial);
          root_n = (root[i] >> 1) + BIT;
        end else begin
          rem_n  = rem[i];
          root_n = root[i] >> 1;
        end
      end
    end else begin : g_hold
      always_comb begin
        rem_n  = rem[i];
        root_n = root[i];
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else if (en) begin
        vld[i+1] <= vld[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        ca[i+1]    <= a_n;
        cb[i+1]    <= b_n;
        acc[i+1]   <= acc_n;
        rem[i+1]   <= rem_n;
        root[i+1]  <= root_n;
        rot[i+1]   <= rot[i];
        xzero[i+1] <= xzero[i];
        yneg[i+1]  <= yneg[i];
      end
    end
  end

  // exit: whole degrees, wrap once, axis override
  logic signed [ACC_W:0] total;
  logic [WH_W-1:0]       whole;
  logic [HDG_W-1:0]      hdg;

  always_comb begin
    total = FULL_TURN + (ACC_W + 1)'(acc[STEPS]);
    whole = total[ACC_W:ANGLE_FRAC_BITS];
    if (whole >= WH_W'(360)) begin
      hdg = HDG_W'(whole - WH_W'(360));
    end else begin
      hdg = HDG_W'(whole);
    end
    if (xzero[STEPS]) begin
      hdg = yneg[STEPS] ? HDG_W'(180) : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= vld[STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_vec.speed   <= root[STEPS][SPD_W-1:0];
      out_vec.heading <= hdg;
      out_vec.rot     <= rot[STEPS];
    end
  end

endmodule

[hw/rtl/omni_mix_wheel.sv]
// Wheel mixer: sector share of the speed per wheel, division by 60 through a
// reciprocal, rotation subtraction, clamp and doubling over three stages.
// Depends on omni_mix_pkg.
module omni_mix_wheel (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                en,
  input  logic                                in_valid,
  input  omni_mix_pkg::vector_t               in_vec,
  input  logic [omni_mix_pkg::LIM_W-1:0]      limit,
  output logic                                out_valid,
  output logic signed [omni_mix_pkg::WHL_W-1:0] wheel_one,
  output logic signed [omni_mix_pkg::WHL_W-1:0] wheel_two,
  output logic signed [omni_mix_pkg::WHL_W-1:0] wheel_three,
  output logic [omni_mix_pkg::MAG_W-1:0]      drive_magnitude,
  output logic [omni_mix_pkg::HDG_W-1:0]      drive_heading
);
  import omni_mix_pkg::*;

  localparam int ANG_W  = HDG_W + 1;
  localparam int COEF_W = 6;
  localparam int PRD_W  = 16;
  localparam int RCP_W  = 17;
  localparam int MUL_W  = PRD_W + RCP_W;
  localparam int W_W    = 12;
  localparam logic [RCP_W-1:0] RECIP_60 = 17'd69906;

  logic    vld1, vld2;
  vector_t vec1, vec2;

  logic [PRD_W-1:0]  prd_q [3];
  logic              neg1  [3];
  logic [SPD_W-1:0]  quo_q [3];
  logic              neg2  [3];
  logic [WHL_W-1:0]  drv   [3];

  for (genvar k = 0; k < 3; k++) begin : g_wheel
    localparam logic [ANG_W-1:0] OFFSET = ANG_W'(120 * k);

    logic [ANG_W-1:0]  ang;
    logic [COEF_W-1:0] coef;
    logic              neg;
    logic [MUL_W-1:0]  mul;
    logic signed [W_W-1:0] share, w, lim_s;

    always_comb begin
      ang = ANG_W'(in_vec.heading) + OFFSET;
      if (ang > ANG_W'(360)) begin
        ang = ang - ANG_W'(360);
      end
      if (ang <= ANG_W'(60)) begin
        coef = COEF_W'(ANG_W'(60) - ang);
        neg  = 1'b0;
      end else if (ang <= ANG_W'(120)) begin
        coef = COEF_W'(ang - ANG_W'(60));
        neg  = 1'b1;
      end else if (ang <= ANG_W'(180)) begin
        coef = COEF_W'(60);
        neg  = 1'b1;
      end else if (ang <= ANG_W'(240)) begin
        coef = COEF_W'(ANG_W'(240) - ang);
        neg  = 1'b1;
      end else if (ang <= ANG_W'(300)) begin
        coef = COEF_W'(ang - ANG_W'(240));
        neg  = 1'b0;
      end else begin
        coef = COEF_W'(60);
        neg  = 1'b0;
      end
    end

    always_comb begin
      mul = MUL_W'(prd_q[k]) * MUL_W'(RECIP_60);
    end

    always_comb begin
      share = neg2[k] ? -$signed({2'b00, quo_q[k]}) : $signed({2'b00, quo_q[k]});
      w     = share - W_W'($signed(vec2.rot));
      lim_s = $signed({3'b000, limit});
      if (w > lim_s) begin
        w = lim_s;
      end else if (w < -lim_s) begin
        w = -lim_s;
      end
      drv[k] = {w[WHL_W-2:0], 1'b0};
    end

    always_ff @(posedge clk) begin
      if (en) begin
        prd_q[k] <= PRD_W'(in_vec.speed) * PRD_W'(coef);
        neg1[k]  <= neg;
        quo_q[k] <= mul[22 +: SPD_W];
        neg2[k]  <= neg1[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld1      <= 1'b0;
      vld2      <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      vld1      <= in_valid;
      vld2      <= vld1;
      out_valid <= vld2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      vec1            <= in_vec;
      vec2            <= vec1;
      wheel_one       <= drv[0];
      wheel_two       <= drv[1];
      wheel_three     <= drv[2];
      drive_heading   <= vec2.heading;
      drive_magnitude <= (vec2.speed > SPD_W'(511)) ? MAG_W'(511) : vec2.speed[MAG_W-1:0];
    end
  end

endmodule

[hw/rtl/three_wheel_omni_drive_mixer.sv]
// Three-wheel omni drive mixer, top level: configuration registers, pipeline
// enable and the scale, vector and wheel units.
// Depends on omni_mix_pkg, omni_mix_scale, omni_mix_vector, omni_mix_wheel.
//
// Use: present y, x and rotation stick commands on the cmd channel (cmd_valid,
// cmd_stall). Each beat yields one beat on the drive channel (drive_valid,
// drive_stall) with three wheel drives, the speed and the heading in degrees.
// The configuration channel (cfg_valid, cfg_ready, cfg_index, cfg_data) writes
// the neutral point (index 0) and motor limit (index 1); cfg_ready is always high.
// Pipeline: two scaling stages, one entry stage, ANGLE_FRAC_BITS + 8 CORDIC
// stages, one heading stage and three wheel stages. Throughput is one beat per
// cycle while drive_stall does not hold a valid beat, set by the CORDIC and root
// pipeline taking one step per stage.
// Reset empties the pipeline and loads neutral 0x8000 and limit 500.
// When drive_stall holds a valid beat, the whole pipeline freezes and cmd_stall
// rises in the same cycle; nothing is lost or repeated.
module three_wheel_omni_drive_mixer #(
  parameter int ANGLE_FRAC_BITS = 20
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cmd_valid,
  output logic                                  cmd_stall,
  input  logic [omni_mix_pkg::RAW_W-1:0]        y_command,
  input  logic [omni_mix_pkg::RAW_W-1:0]        x_command,
  input  logic [omni_mix_pkg::RAW_W-1:0]        rotation_command,
  output logic                                  drive_valid,
  input  logic                                  drive_stall,
  output logic signed [omni_mix_pkg::WHL_W-1:0] wheel_one,
  output logic signed [omni_mix_pkg::WHL_W-1:0] wheel_two,
  output logic signed [omni_mix_pkg::WHL_W-1:0] wheel_three,
  output logic [omni_mix_pkg::MAG_W-1:0]        drive_magnitude,
  output logic [omni_mix_pkg::HDG_W-1:0]        drive_heading,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [0:0]                            cfg_index,
  input  logic [omni_mix_pkg::RAW_W-1:0]        cfg_data
);
  import omni_mix_pkg::*;

  logic [RAW_W-1:0] neutral;
  logic [LIM_W-1:0] limit;
  logic             en;
  logic             scl_valid, vec_valid;
  scaled_cmd_t      scl_cmd;
  vector_t          vec;

  assign cfg_ready = 1'b1;
  assign en        = !drive_valid || !drive_stall;
  assign cmd_stall = !en;

  always_ff @(posedge clk) begin
    if (rst) begin
      neutral <= NEUTRAL_RESET;
      limit   <= LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_NEUTRAL: neutral <= cfg_data;
        REG_LIMIT:   limit   <= cfg_data[LIM_W-1:0];
        default:     ;
      endcase
    end
  end

  omni_mix_scale u_scale (
    .clk              (clk),
    .rst              (rst),
    .en               (en),
    .in_valid         (cmd_valid),
    .y_command        (y_command),
    .x_command        (x_command),
    .rotation_command (rotation_command),
    .neutral          (neutral),
    .out_valid        (scl_valid),
    .out_cmd          (scl_cmd)
  );

  omni_mix_vector #(
    .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
  ) u_vector (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (scl_valid),
    .in_cmd    (scl_cmd),
    .out_valid (vec_valid),
    .out_vec   (vec)
  );

  omni_mix_wheel u_wheel (
    .clk             (clk),
    .rst             (rst),
    .en              (en),
    .in_valid        (vec_valid),
    .in_vec          (vec),
    .limit           (limit),
    .out_valid       (drive_valid),
    .wheel_one       (wheel_one),
    .wheel_two       (wheel_two),
    .wheel_three     (wheel_three),
    .drive_magnitude (drive_magnitude),
    .drive_heading   (drive_heading)
  );

endmodule

[hw/rtl/omni_mix_checker.sv]
// Port checker for the three-wheel omni drive mixer, attached by bind.
// Depends on omni_mix_pkg and three_wheel_omni_drive_mixer.
module omni_mix_assertions (
  input logic                                  clk,
  input logic                                  rst,
  input logic                                  cmd_stall,
  input logic                                  drive_valid,
  input logic                                  drive_stall,
  input logic signed [omni_mix_pkg::WHL_W-1:0] wheel_one,
  input logic [omni_mix_pkg::HDG_W-1:0]        drive_heading
);
  import omni_mix_pkg::*;

  a_reset_empty: assert property (@(posedge clk) rst |=> !drive_valid)
    else $error("drive beat present after reset");

  a_stall_source: assert property (@(posedge clk) disable iff (rst)
    cmd_stall |-> (drive_valid && drive_stall))
    else $error("cmd stalled without a held drive beat");

  a_hold_beat: assert property (@(posedge clk) disable iff (rst)
    (drive_valid && drive_stall) |=>
      (drive_valid && $stable(drive_heading) && $stable(wheel_one)))
    else $error("stalled drive beat changed");

  a_heading_range: assert property (@(posedge clk) disable iff (rst)
    drive_valid |-> (drive_heading < HDG_W'(360)))
    else $error("heading out of range");

endmodule

bind three_wheel_omni_drive_mixer omni_mix_assertions u_omni_mix_assertions (.*);

[bench/omni_mix_checker.sv]
// Checker for the three-wheel omni drive mixer: watches the command, drive and
// configuration channels, predicts every drive beat and compares it field by field.
// Depends on omni_mix_pkg.
`timescale 1ns / 100ps
module omni_mix_checker #(
  parameter int FRAC = 20
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cmd_valid,
  input  logic                                  cmd_stall,
  input  logic [omni_mix_pkg::RAW_W-1:0]        y_command,
  input  logic [omni_mix_pkg::RAW_W-1:0]        x_command,
  input  logic [omni_mix_pkg::RAW_W-1:0]        rotation_command,
  input  logic                                  drive_valid,
  input  logic                                  drive_stall,
  input  logic signed [omni_mix_pkg::WHL_W-1:0] wheel_one,
  input  logic signed [omni_mix_pkg::WHL_W-1:0] wheel_two,
  input  logic signed [omni_mix_pkg::WHL_W-1:0] wheel_three,
  input  logic [omni_mix_pkg::MAG_W-1:0]        drive_magnitude,
  input  logic [omni_mix_pkg::HDG_W-1:0]        drive_heading,
  input  logic                                  cfg_valid,
  input  logic                                  cfg_ready,
  input  logic [0:0]                            cfg_index,
  input  logic [omni_mix_pkg::RAW_W-1:0]        cfg_data,
  output int                                    errors,
  output int                                    pending,
  output int                                    beats_seen
);
  import omni_mix_pkg::*;

  typedef struct packed {
    logic signed [WHL_W-1:0] w1;
    logic signed [WHL_W-1:0] w2;
    logic signed [WHL_W-1:0] w3;
    logic [MAG_W-1:0]        mag;
    logic [HDG_W-1:0]        hdg;
  } drive_t;

  localparam int STEPS = FRAC + 8;

  drive_t          drive_q[$];
  longint          rot_step[0:STEPS-1];
  logic [RAW_W-1:0] neutral;
  logic [LIM_W-1:0] limit;

  function automatic longint unsigned arctan_inv(longint unsigned m);
    longint unsigned p, sum, t;
    p = (64'd1 << 56) / m;
    sum = p;
    for (int k = 1; k < 64; k++) begin
      p = p / m;
      p = p / m;
      if (p == 0) break;
      t = p / longint'(2 * k + 1);
      if (k % 2) sum = sum - t;
      else sum = sum + t;
    end
    return sum;
  endfunction

  initial begin
    longint unsigned r, d;
    for (int i = 0; i < STEPS; i++) begin
      if (i == 0) r = 4 * arctan_inv(5) - arctan_inv(239);
      else r = arctan_inv(64'd1 << i);
      d = (r / 10000) * 572958 + ((r % 10000) * 572958) / 10000;
      rot_step[i] = longint'(d >> (56 - FRAC));
    end
  end

  function automatic int centre(logic [RAW_W-1:0] raw);
    int v;
    v = int'(raw) - int'(neutral);
    return v * 500 / 65535;
  endfunction

  function automatic int bearing(int x, int y);
    longint a, b, acc, t, ai, bi, total;
    if (x == 0) return (y < 0) ? 180 : 0;
    a = longint'(y) <<< 32;
    b = longint'(x) <<< 32;
    acc = 0;
    if (a < 0) begin
      t = a;
      if (b >= 0) begin
        a = b; b = -t; acc = 2 * rot_step[0];
      end else begin
        a = -b; b = t; acc = -2 * rot_step[0];
      end
    end
    for (int i = 0; i < STEPS; i++) begin
      ai = a >>> i;
      bi = b >>> i;
      if (b >= 0) begin
        a = a + bi; b = b - ai; acc = acc + rot_step[i];
      end else begin
        a = a - bi; b = b + ai; acc = acc - rot_step[i];
      end
    end
    total = (longint'(360) <<< FRAC) + acc;
    if (total < 0) total = 0;
    return int'((total >>> FRAC) % 360);
  endfunction

  function automatic int root(int v);
    int r, bitv;
    r = 0;
    bitv = 1 << 30;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= r + bitv) begin
        v = v - (r + bitv);
        r = (r >> 1) + bitv;
      end else begin
        r = r >> 1;
      end
      bitv = bitv >> 2;
    end
    return r;
  endfunction

  function automatic int share(int ang, int s);
    if (ang > 360) ang = ang - 360;
    if (ang <= 60) return s * (60 - ang) / 60;
    if (ang <= 120) return -s * (ang - 60) / 60;
    if (ang <= 180) return -s;
    if (ang <= 240) return -s * (240 - ang) / 60;
    if (ang <= 300) return s * (ang - 240) / 60;
    return s;
  endfunction

  function automatic drive_t mix(logic [RAW_W-1:0] yr, logic [RAW_W-1:0] xr,
                                 logic [RAW_W-1:0] rr);
    int ys, xs, rot, spd, hdg, w, lim;
    int wv[3];
    drive_t d;
    ys = centre(yr);
    xs = centre(xr);
    rot = centre(rr);
    lim = int'(limit);
    spd = (xs != 0 || ys != 0) ? root(xs * xs + ys * ys) : 0;
    hdg = bearing(xs, ys);
    for (int k = 0; k < 3; k++) begin
      w = share(hdg + 120 * k, spd) - rot;
      if (w > lim) w = lim;
      else if (w < -lim) w = -lim;
      wv[k] = 2 * w;
    end
    d.w1 = WHL_W'(wv[0]);
    d.w2 = WHL_W'(wv[1]);
    d.w3 = WHL_W'(wv[2]);
    d.mag = (spd > 511) ? 9'd511 : MAG_W'(spd);
    d.hdg = HDG_W'(hdg);
    return d;
  endfunction

  task automatic report(string what, int got, int want);
    $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
    errors++;
  endtask

  assign pending = drive_q.size();

  initial begin
    errors = 0;
    beats_seen = 0;
  end

  always @(posedge clk) begin
    drive_t e;
    if (rst) begin
      neutral <= NEUTRAL_RESET;
      limit <= LIMIT_RESET;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_NEUTRAL) neutral <= cfg_data;
        else if (cfg_index == REG_LIMIT) limit <= cfg_data[LIM_W-1:0];
      end
      if (cmd_valid && !cmd_stall) drive_q.push_back(mix(y_command, x_command, rotation_command));
      if (drive_valid && !drive_stall) begin
        beats_seen++;
        if (drive_q.size() == 0) begin
          $display("drive beat at %0t with nothing outstanding", $realtime);
          errors++;
        end else begin
          e = drive_q.pop_front();
          if (wheel_one !== e.w1) report("wheel_one", wheel_one, e.w1);
          if (wheel_two !== e.w2) report("wheel_two", wheel_two, e.w2);
          if (wheel_three !== e.w3) report("wheel_three", wheel_three, e.w3);
          if (drive_magnitude !== e.mag) report("drive_magnitude", drive_magnitude, e.mag);
          if (drive_heading !== e.hdg) report("drive_heading", drive_heading, e.hdg);
        end
      end
    end
  end
endmodule

[bench/tb.sv]
// Testbench top for the three-wheel omni drive mixer: clock, reset, command and
// configuration stimulus, drive stalls, watchdog and verdict.
// Depends on omni_mix_pkg, three_wheel_omni_drive_mixer and omni_mix_checker.
`timescale 1ns / 100ps
module tb;
  import omni_mix_pkg::*;

  localparam int LATENCY = 35;
  localparam int WATCHDOG = 3000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cmd_valid = 1'b0;
  logic cmd_stall;
  logic [RAW_W-1:0] y_command = '0;
  logic [RAW_W-1:0] x_command = '0;
  logic [RAW_W-1:0] rotation_command = '0;
  logic drive_valid;
  logic drive_stall = 1'b0;
  logic signed [WHL_W-1:0] wheel_one, wheel_two, wheel_three;
  logic [MAG_W-1:0] drive_magnitude;
  logic [HDG_W-1:0] drive_heading;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [0:0] cfg_index = REG_NEUTRAL;
  logic [RAW_W-1:0] cfg_data = '0;
  int errors, pending, beats_seen;
  int items_sent = 0;
  int quiet = 0;
  int stall_left = 0;
  bit calm = 1'b0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  three_wheel_omni_drive_mixer u_top (.*);

  omni_mix_checker u_chk (.*);

  // drive stalls: hold for a drawn number of cycles after each beat
  always @(posedge clk) begin
    int w;
    if (drive_valid && !drive_stall) begin
      w = calm ? 0 : $urandom_range(0, 16);
      stall_left <= w;
      drive_stall <= (w != 0);
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      drive_stall <= (stall_left > 1);
    end
  end

  always @(posedge clk) begin
    if ((cmd_valid && !cmd_stall) || (drive_valid && !drive_stall) || rst) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= WATCHDOG) begin
      $display("watchdog expired with %0d beats outstanding", pending);
      $display("tb: FAIL");
      $finish;
    end
  end

  task automatic send(logic [RAW_W-1:0] y, logic [RAW_W-1:0] x, logic [RAW_W-1:0] r);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      cmd_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_valid <= 1'b1;
    y_command <= y;
    x_command <= x;
    rotation_command <= r;
    do @(posedge clk); while (cmd_stall);
    items_sent++;
  endtask

  task automatic configure(logic [RAW_W-1:0] np, logic [LIM_W-1:0] lim);
    cmd_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (LATENCY) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= REG_NEUTRAL;
    cfg_data <= np;
    do @(posedge clk); while (!cfg_ready);
    cfg_index <= REG_LIMIT;
    cfg_data <= RAW_W'(lim);
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [RAW_W-1:0] near(logic [RAW_W-1:0] np);
    return np + RAW_W'($urandom_range(0, 1200)) - RAW_W'(600);
  endfunction

  task automatic random_items(logic [RAW_W-1:0] np, int n);
    logic [RAW_W-1:0] y, x, r;
    for (int i = 0; i < n; i++) begin
      if (i % 40 == 0) calm = ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 3))
        0: begin
          y = RAW_W'($urandom); x = RAW_W'($urandom); r = RAW_W'($urandom);
        end
        1: begin
          y = near(np); x = np; r = near(np);
        end
        default: begin
          y = near(np) + RAW_W'($urandom_range(0, 8000)) - RAW_W'(4000);
          x = near(np) + RAW_W'($urandom_range(0, 8000)) - RAW_W'(4000);
          r = ($urandom_range(0, 1)) ? np : near(np);
        end
      endcase
      send(y, x, r);
    end
  endtask

  initial begin
    logic [RAW_W-1:0] np;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    configure(NEUTRAL_RESET, LIMIT_RESET);
    send(16'h8000, 16'h8000, 16'h8000);
    send(16'h0000, 16'h0000, 16'h0000);
    send(16'hFFFF, 16'hFFFF, 16'hFFFF);
    send(16'hFFFF, 16'h0000, 16'h8000);
    send(16'h0000, 16'hFFFF, 16'h8000);
    send(16'h0000, 16'h8000, 16'h8000);
    send(16'hFFFF, 16'h8000, 16'h8000);
    send(16'h8000, 16'hFFFF, 16'h0000);
    send(16'h8000, 16'h0000, 16'hFFFF);
    send(16'h8000, 16'h8084, 16'h8000);
    send(16'h7F7C, 16'h8084, 16'h8000);
    send(16'h8000, 16'h80FF, 16'h8000);
    send(16'h7FFF, 16'h8001, 16'h8000);
    send(16'h5555, 16'hAAAA, 16'h5555);
    send(16'hAAAA, 16'h5555, 16'hAAAA);
    random_items(NEUTRAL_RESET, 160);
    configure(16'h0000, 9'd0);
    send(16'hFFFF, 16'hFFFF, 16'h0000);
    send(16'hFFFF, 16'h0000, 16'hFFFF);
    random_items(16'h0000, 160);
    configure(16'hFFFF, 9'd511);
    send(16'h0000, 16'h0000, 16'hFFFF);
    send(16'h0000, 16'hFFFF, 16'h0000);
    random_items(16'hFFFF, 160);
    configure(16'h0000, 9'd511);
    send(16'hFFFF, 16'hFFFF, 16'h0000);
    send(16'hFFFF, 16'hFFFF, 16'hFFFF);
    random_items(16'h0000, 160);
    np = RAW_W'($urandom);
    configure(np, 9'($urandom_range(1, 510)));
    random_items(np, 190);
    cmd_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    $display("covered %0d commands and %0d drive beats over five register settings",
             items_sent, beats_seen);
    if (errors == 0) begin
      $display("tb: PASS");
    end else begin
      $display("%0d mismatches", errors);
      $display("tb: FAIL");
    end
    $finish;
  end
endmodule
